@@ sv/rsba_pkg.sv @@
// shared types and constants for the random span bitmap allocator
`default_nettype none
package rsba_pkg;

  localparam int MAP_ENTRIES_DEFAULT = 256;
  localparam int ENTRY_BASE = 256;
  localparam int MIN_FREE_RESET = 100;

  localparam int FIELD_W = 9;
  localparam int RAND_W = 32;
  localparam int DIV_STEPS_W = $clog2(RAND_W);

  localparam logic CMD_RESERVE = 1'b0;
  localparam logic CMD_ACQUIRE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COUNT,
    ST_DIV,
    ST_SELECT,
    ST_MARK
  } state_t;

endpackage
`default_nettype wire

@@ sv/random_span_bitmap_allocator.sv @@
// occupancy map allocator: reserve a given run or acquire a random free window
// a failed reserve, a reserve of zero entries or an acquire with a bad count strobes
//   done in the cycle after start; a good reserve marks its entries in turn, then strobes done
// an acquire counts the free windows over the map, divides the random value by that count,
//   scans to the window whose rank is the remainder and marks it; too few windows: fails
//   at the end of the count pass. one command at a time; busy is high until the result strobe, which cannot be held
// synchronous reset clears the map and busy, and loads min_free with 100
`default_nettype none
module random_span_bitmap_allocator
  import rsba_pkg::*;
#(
  parameter int MAP_ENTRIES = MAP_ENTRIES_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic                command,
  input  wire logic [FIELD_W-1:0]  first_entry,
  input  wire logic [FIELD_W-1:0]  entry_count,
  input  wire logic [RAND_W-1:0]   random_value,
  input  wire logic                cfg_we,
  input  wire logic [FIELD_W-1:0]  cfg_wdata,
  output logic                     done,
  output logic [FIELD_W-1:0]       granted_entry,
  output logic                     failed
);

  localparam int PW = $clog2(MAP_ENTRIES);
  localparam int LW = $clog2(MAP_ENTRIES + 1);
  localparam int XW = ((LW > FIELD_W) ? LW : FIELD_W) + 2;
  localparam logic [PW-1:0] LAST_IDX = PW'(MAP_ENTRIES - 1);

  state_t state, state_next;

  logic [MAP_ENTRIES-1:0] occ_map;
  logic [FIELD_W-1:0]     min_free;

  logic [FIELD_W-1:0]     count_q;
  logic [RAND_W-1:0]      rnd_sh;
  logic [PW-1:0]          idx;
  logic [LW-1:0]          run;
  logic [LW-1:0]          avail;
  logic [LW-1:0]          rank;
  logic [DIV_STEPS_W-1:0] div_step;
  logic [PW-1:0]          mark_ptr;
  logic [FIELD_W-1:0]     remain;

  // shared scan and compare unit
  logic          cur_free;
  logic [LW-1:0] run_new;
  logic          hit;
  logic          last_idx;
  logic [LW-1:0] avail_final;
  logic          too_few;
  logic [LW:0]   rem_sh;
  logic          rem_ge;
  logic [LW-1:0] rem_new;
  logic [PW-1:0] win_pos;
  logic          reserve_bad;
  logic          acquire_bad;
  logic          accept;
  logic          found;
  logic          mark_last;

  always_comb begin
    cur_free    = ~occ_map[idx];
    run_new     = cur_free ? LW'(run + 1'b1) : '0;
    hit         = cur_free && (XW'(run_new) >= XW'(count_q));
    last_idx    = (idx == LAST_IDX);
    avail_final = LW'(avail + LW'(hit));
    too_few     = (avail_final == '0) || (XW'(avail_final) < XW'(min_free));
    rem_sh      = {rank, rnd_sh[RAND_W-1]};
    rem_ge      = rem_sh >= {1'b0, avail};
    rem_new     = rem_ge ? LW'(rem_sh - {1'b0, avail}) : LW'(rem_sh);
    win_pos     = PW'(XW'(idx) + XW'(1) - XW'(count_q));
    found       = hit && (rank == '0);
    mark_last   = (remain == FIELD_W'(1));
    reserve_bad = ~first_entry[FIELD_W-1] ||
                  (XW'(first_entry[FIELD_W-2:0]) + XW'(entry_count) > XW'(MAP_ENTRIES));
    acquire_bad = (entry_count == '0) || (XW'(entry_count) > XW'(MAP_ENTRIES));
  end

  // outputs of the sequencer
  always_comb begin
    busy   = (state != ST_IDLE);
    accept = start && (state == ST_IDLE);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (command == CMD_ACQUIRE) begin
            state_next = acquire_bad ? ST_IDLE : ST_COUNT;
          end else if (!reserve_bad && entry_count != '0) begin
            state_next = ST_MARK;
          end
        end
      end
      ST_COUNT: begin
        if (last_idx) state_next = too_few ? ST_IDLE : ST_DIV;
      end
      ST_DIV: begin
        if (div_step == DIV_STEPS_W'(RAND_W - 1)) state_next = ST_SELECT;
      end
      ST_SELECT: begin
        if (found) state_next = ST_MARK;
      end
      ST_MARK: begin
        if (mark_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      occ_map  <= '0;
      min_free <= FIELD_W'(MIN_FREE_RESET);
      done     <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (cfg_we) min_free <= cfg_wdata;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            count_q <= entry_count;
            rnd_sh  <= random_value;
            idx     <= '0;
            run     <= '0;
            avail   <= '0;
            remain  <= entry_count;
            mark_ptr <= PW'(first_entry[FIELD_W-2:0]);
            if (command == CMD_ACQUIRE) begin
              granted_entry <= '0;
              failed        <= 1'b0;
              if (acquire_bad) begin
                failed <= 1'b1;
                done   <= 1'b1;
              end
            end else begin
              granted_entry <= first_entry;
              failed        <= reserve_bad;
              if (reserve_bad || entry_count == '0) done <= 1'b1;
            end
          end
        end
        ST_COUNT: begin
          run   <= run_new;
          avail <= avail_final;
          idx   <= idx + 1'b1;
          rank  <= '0;
          div_step <= '0;
          if (last_idx && too_few) begin
            failed <= 1'b1;
            done   <= 1'b1;
          end
        end
        ST_DIV: begin
          // restoring remainder, one dividend bit a beat
          rank     <= rem_new;
          rnd_sh   <= {rnd_sh[RAND_W-2:0], 1'b0};
          div_step <= div_step + 1'b1;
          idx      <= '0;
          run      <= '0;
        end
        ST_SELECT: begin
          run <= run_new;
          idx <= idx + 1'b1;
          if (found) begin
            mark_ptr      <= win_pos;
            granted_entry <= FIELD_W'(ENTRY_BASE + int'(win_pos));
          end else if (hit) begin
            rank <= rank - 1'b1;
          end
        end
        ST_MARK: begin
          occ_map[mark_ptr] <= 1'b1;
          mark_ptr <= mark_ptr + 1'b1;
          remain   <= remain - 1'b1;
          if (mark_last) done <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // map bits are only ever set outside reset
  a_map_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (($past(occ_map) & ~occ_map) == '0))
    else $error("occupancy bit cleared outside reset");

  // the remainder chosen as rank never reaches the window count
  a_rank_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SELECT) |-> (rank < avail))
    else $error("rank not below free window count");

  // an accepted command either finishes at once or keeps the block busy
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted command neither busy nor done");

  // a failed command leaves no trace in the map
  a_fail_no_mark: assert property (@(posedge clk) disable iff (rst)
    (done && failed && !$past(rst)) |-> (occ_map == $past(occ_map)))
    else $error("map changed on a failed command");

endmodule
`default_nettype wire
